// ===== rtl/core/fssa_pkg.sv =====
// Shared types, constants and helpers for the fixed-size slab allocator.
package fssa_pkg;

  localparam int MAX_SLABS          = 64;
  localparam int MAX_ITEMS_PER_SLAB = 128;
  localparam int STACK_DEPTH        = MAX_SLABS * MAX_ITEMS_PER_SLAB;

  localparam int SLAB_W   = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int IPB_W    = $clog2(MAX_ITEMS_PER_SLAB + 1);
  localparam int ADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TOP_W    = ADDR_W + 1;
  localparam int HANDLE_W = 13;
  localparam int COUNT_W  = 14;
  localparam int SIZE_W   = 16;
  localparam int CFG_IPB_W = 8;
  localparam int BYTES_W  = 32;
  localparam int STATUS_W = 3;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_LIMIT   = 3'd1,
    ST_NO_SLAB = 3'd2,
    ST_BAD_HDL = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_ITEM_SIZE  = 2'd0,
    REG_ITEMS_SLAB = 2'd1,
    REG_MEM_LIMIT  = 2'd2,
    REG_STATS_EN   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  item_size;
    logic [IPB_W-1:0]   ipb;
    logic [BYTES_W-1:0] mem_limit;
    logic               stats_en;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic decide;
    logic load_out;
  } cmd_t;

  // Clamp the slab size setting into 1 .. MAX_ITEMS_PER_SLAB.
  function automatic logic [IPB_W-1:0] eff_ipb(input logic [CFG_IPB_W-1:0] raw);
    logic [IPB_W-1:0] res;
    if (raw == '0) begin
      res = IPB_W'(1);
    end else if (32'(raw) > MAX_ITEMS_PER_SLAB) begin
      res = IPB_W'(MAX_ITEMS_PER_SLAB);
    end else begin
      res = IPB_W'(raw);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/fssa_regs.sv =====
// Configuration register file behind the APB-style port.
module fssa_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fssa_pkg::APB_AW-1:0]  paddr,
  input  logic [fssa_pkg::APB_DW-1:0]  pwdata,
  output logic [fssa_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output fssa_pkg::cfg_t               cfg
);

  logic [fssa_pkg::SIZE_W-1:0]    item_size_r;
  logic [fssa_pkg::CFG_IPB_W-1:0] ipb_r;
  logic [fssa_pkg::BYTES_W-1:0]   limit_r;
  logic                           stats_r;
  fssa_pkg::reg_idx_t             idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = fssa_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_size_r <= fssa_pkg::SIZE_W'(16);
      ipb_r       <= fssa_pkg::CFG_IPB_W'(32);
      limit_r     <= '0;
      stats_r     <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        fssa_pkg::REG_ITEM_SIZE:  item_size_r <= pwdata[fssa_pkg::SIZE_W-1:0];
        fssa_pkg::REG_ITEMS_SLAB: ipb_r       <= pwdata[fssa_pkg::CFG_IPB_W-1:0];
        fssa_pkg::REG_MEM_LIMIT:  limit_r     <= pwdata[fssa_pkg::BYTES_W-1:0];
        fssa_pkg::REG_STATS_EN:   stats_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fssa_pkg::REG_ITEM_SIZE:  prdata = fssa_pkg::APB_DW'(item_size_r);
      fssa_pkg::REG_ITEMS_SLAB: prdata = fssa_pkg::APB_DW'(ipb_r);
      fssa_pkg::REG_MEM_LIMIT:  prdata = fssa_pkg::APB_DW'(limit_r);
      fssa_pkg::REG_STATS_EN:   prdata = fssa_pkg::APB_DW'(stats_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.item_size = item_size_r;
  assign cfg.ipb       = fssa_pkg::eff_ipb(ipb_r);
  assign cfg.mem_limit = limit_r;
  assign cfg.stats_en  = stats_r;

endmodule

// ===== rtl/core/fssa_ctrl.sv =====
// Sequencer: steps one transaction through capture, calc, decide and output.
module fssa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output fssa_pkg::cmd_t  cmd
);

  fssa_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != fssa_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fssa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      fssa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = fssa_pkg::S_CALC;
        end
      end
      fssa_pkg::S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = fssa_pkg::S_DECIDE;
      end
      fssa_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = fssa_pkg::S_OUT;
      end
      fssa_pkg::S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fssa_pkg::S_IDLE;
        end
      end
      default: state_nxt = fssa_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == fssa_pkg::S_CALC))
    else $error("accepted transaction did not enter calc");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fssa_pkg::S_OUT && out_free) |=> (out_valid_r && state_r == fssa_pkg::S_IDLE))
    else $error("result not loaded from output state");

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fssa_pkg::S_OUT))
    else $error("result appeared outside output state");
`endif

endmodule

// ===== rtl/core/fssa_dp.sv =====
// Datapath: allocator state, free stack memory, stats and result register.
module fssa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fssa_pkg::cmd_t                 cmd,
  input  fssa_pkg::cfg_t                 cfg,
  input  logic                           in_op,
  input  logic [fssa_pkg::HANDLE_W-1:0]  in_handle,
  output logic [fssa_pkg::HANDLE_W-1:0]  out_result_handle,
  output logic [fssa_pkg::STATUS_W-1:0]  out_status,
  output logic [fssa_pkg::COUNT_W-1:0]   out_bumped_count,
  output logic [fssa_pkg::COUNT_W-1:0]   out_free_count,
  output logic [fssa_pkg::BYTES_W-1:0]   out_usage_bytes,
  output logic [fssa_pkg::BYTES_W-1:0]   out_peak_bytes
);

  localparam int CW = fssa_pkg::COUNT_W;
  localparam int BW = fssa_pkg::BYTES_W;

  // allocator state
  logic [fssa_pkg::SLAB_W-1:0] slab_r, slab_nxt;
  logic [fssa_pkg::IPB_W-1:0]  slot_r, slot_nxt;
  logic [fssa_pkg::TOP_W-1:0]  free_top_r, free_top_nxt;
  logic [BW-1:0]               usage_r, usage_nxt;
  logic [BW-1:0]               peak_r, peak_nxt;

  // captured transaction
  fssa_pkg::op_t               op_r;
  logic [fssa_pkg::HANDLE_W-1:0] handle_r;

  // precomputed terms
  logic [CW-1:0] bump_r, cap_r;
  logic [BW-1:0] inc_r, dec_r;
  logic          need_new_r, last_slab_r;
  logic [BW:0]   inc_sum;

  // decision results
  logic [fssa_pkg::HANDLE_W-1:0] res_r, res_nxt;
  fssa_pkg::status_t             status_r, status_nxt;
  logic [CW-1:0]                 bumped_r, bumped_nxt;
  logic                          pop_r, pop_nxt;
  logic                          push_en;
  logic                          limit_hit;

  // free stack
  logic [fssa_pkg::HANDLE_W-1:0] stack_mem [fssa_pkg::STACK_DEPTH];
  logic [fssa_pkg::HANDLE_W-1:0] rd_data_r;
  logic [fssa_pkg::ADDR_W-1:0]   rd_addr;

  // output register
  logic [fssa_pkg::HANDLE_W-1:0] o_handle_r;
  fssa_pkg::status_t             o_status_r;
  logic [CW-1:0]                 o_bumped_r, o_free_r;
  logic [BW-1:0]                 o_usage_r, o_peak_r;

  assign inc_sum = {1'b0, usage_r} + (BW + 1)'(cfg.item_size);
  assign rd_addr = fssa_pkg::ADDR_W'(free_top_r - fssa_pkg::TOP_W'(1));

  assign limit_hit = cfg.stats_en && (inc_r > peak_r) && (cfg.mem_limit != '0)
                     && (inc_r > cfg.mem_limit) && (peak_r <= cfg.mem_limit);

  always_comb begin
    slab_nxt     = slab_r;
    slot_nxt     = slot_r;
    free_top_nxt = free_top_r;
    usage_nxt    = usage_r;
    peak_nxt     = peak_r;
    res_nxt      = '0;
    status_nxt   = fssa_pkg::ST_OK;
    bumped_nxt   = bump_r;
    pop_nxt      = 1'b0;
    push_en      = 1'b0;
    if (cmd.decide) begin
      case (op_r)
        fssa_pkg::OP_ALLOC: begin
          if (free_top_r != '0 || !(need_new_r && last_slab_r)) begin
            // usage and peak move even when the limit trips
            if (cfg.stats_en) begin
              usage_nxt = inc_r;
              if (inc_r > peak_r) begin
                peak_nxt = inc_r;
              end
            end
          end
          if (free_top_r != '0) begin
            if (limit_hit) begin
              status_nxt = fssa_pkg::ST_LIMIT;
            end else begin
              free_top_nxt = free_top_r - fssa_pkg::TOP_W'(1);
              pop_nxt      = 1'b1;
            end
          end else if (need_new_r && last_slab_r) begin
            status_nxt = fssa_pkg::ST_NO_SLAB;
          end else if (limit_hit) begin
            status_nxt = fssa_pkg::ST_LIMIT;
          end else if (need_new_r) begin
            slab_nxt   = slab_r + fssa_pkg::SLAB_W'(1);
            slot_nxt   = fssa_pkg::IPB_W'(1);
            res_nxt    = cap_r[fssa_pkg::HANDLE_W-1:0];
            bumped_nxt = cap_r + CW'(1);
          end else begin
            slot_nxt   = slot_r + fssa_pkg::IPB_W'(1);
            res_nxt    = bump_r[fssa_pkg::HANDLE_W-1:0];
            bumped_nxt = bump_r + CW'(1);
          end
        end
        fssa_pkg::OP_FREE: begin
          if (CW'(handle_r) >= cap_r) begin
            status_nxt = fssa_pkg::ST_BAD_HDL;
          end else if (CW'(free_top_r) >= cap_r) begin
            status_nxt = fssa_pkg::ST_FULL;
          end else begin
            push_en      = 1'b1;
            free_top_nxt = free_top_r + fssa_pkg::TOP_W'(1);
            if (cfg.stats_en) begin
              usage_nxt = dec_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slab_r     <= '0;
      slot_r     <= '0;
      free_top_r <= '0;
      usage_r    <= '0;
      peak_r     <= '0;
    end else begin
      slab_r     <= slab_nxt;
      slot_r     <= slot_nxt;
      free_top_r <= free_top_nxt;
      usage_r    <= usage_nxt;
      peak_r     <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= fssa_pkg::op_t'(in_op);
      handle_r <= in_handle;
    end
    if (cmd.calc) begin
      bump_r      <= CW'(slab_r) * CW'(cfg.ipb) + CW'(slot_r);
      cap_r       <= (CW'(slab_r) + CW'(1)) * CW'(cfg.ipb);
      inc_r       <= inc_sum[BW] ? {BW{1'b1}} : inc_sum[BW-1:0];
      dec_r       <= (usage_r < BW'(cfg.item_size)) ? '0 : usage_r - BW'(cfg.item_size);
      need_new_r  <= (slot_r >= cfg.ipb);
      last_slab_r <= (slab_r == fssa_pkg::SLAB_W'(fssa_pkg::MAX_SLABS - 1));
    end
    if (cmd.decide) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
      bumped_r <= bumped_nxt;
      pop_r    <= pop_nxt;
    end
    if (cmd.load_out) begin
      o_handle_r <= pop_r ? rd_data_r : res_r;
      o_status_r <= status_r;
      o_bumped_r <= bumped_r;
      o_free_r   <= CW'(free_top_r);
      o_usage_r  <= usage_r;
      o_peak_r   <= peak_r;
    end
  end

  // stack memory with one write and one read port: push writes at the top, pop reads just below it
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[free_top_r[fssa_pkg::ADDR_W-1:0]] <= handle_r;
    end
    if (cmd.decide) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  assign out_result_handle = o_handle_r;
  assign out_status        = o_status_r;
  assign out_bumped_count  = o_bumped_r;
  assign out_free_count    = o_free_r;
  assign out_usage_bytes   = o_usage_r;
  assign out_peak_bytes    = o_peak_r;

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= fssa_pkg::TOP_W'(fssa_pkg::STACK_DEPTH))
    else $error("free stack top beyond depth");

  a_state_only_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.decide) |-> ($stable(slab_r) && $stable(slot_r) && $stable(free_top_r)))
    else $error("allocator state moved outside decide");

  a_peak_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.decide && cfg.stats_en && op_r == fssa_pkg::OP_ALLOC
          && status_nxt == fssa_pkg::ST_OK) |-> (peak_r >= usage_r))
    else $error("peak below usage after allocate");
`endif

endmodule

// ===== rtl/core/fixed_size_slab_allocator.sv =====
// Top level of the fixed-size slab allocator: register file, sequencer, datapath.
//
// Usage:
//   Input channel (in_valid / in_stall, in_op, in_handle) carries one request
//   per transaction: allocate (op 0) or free the given handle (op 1).
//   Result channel (out_valid / out_stall) returns exactly one result per
//   request: handle, status, bump count, free-stack fill, usage and peak bytes.
//   Configure item size, slab size, byte limit and stats enable through the
//   APB-style port only while no request is in flight; pready is tied high.
// Timing:
//   A request passes through accept, precompute (index multiply, usage add),
//   decide (state update plus free-stack memory access) and output load.
//   The next request is accepted only once the sequencer is back in idle,
//   after the previous result has loaded into the output register.
//   The free-stack memory's registered read port sets the decide/output split.
// Stall:
//   A stalled result holds in the output register. The next request is still
//   accepted and worked; it waits in the output step until the result leaves.
// Reset:
//   Synchronous, active low. Slab, slot, free-stack top, usage and peak clear,
//   registers return to defaults. Free-stack contents are not cleared.
module fixed_size_slab_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [fssa_pkg::HANDLE_W-1:0]  in_handle,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fssa_pkg::HANDLE_W-1:0]  out_result_handle,
  output logic [fssa_pkg::STATUS_W-1:0]  out_status,
  output logic [fssa_pkg::COUNT_W-1:0]   out_bumped_count,
  output logic [fssa_pkg::COUNT_W-1:0]   out_free_count,
  output logic [fssa_pkg::BYTES_W-1:0]   out_usage_bytes,
  output logic [fssa_pkg::BYTES_W-1:0]   out_peak_bytes,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fssa_pkg::APB_AW-1:0]    paddr,
  input  logic [fssa_pkg::APB_DW-1:0]    pwdata,
  output logic [fssa_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  fssa_pkg::cfg_t cfg;
  fssa_pkg::cmd_t cmd;

  // configuration registers, clamped slab size goes straight to the datapath
  fssa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer owns both handshakes
  fssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath does the arithmetic, stack memory and result register
  fssa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg),
    .in_op             (in_op),
    .in_handle         (in_handle),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_bumped_count  (out_bumped_count),
    .out_free_count    (out_free_count),
    .out_usage_bytes   (out_usage_bytes),
    .out_peak_bytes    (out_peak_bytes)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the fixed-size slab allocator: directed cases plus random traffic.
`timescale 1ns / 100ps

module tb;

  // One result transaction as the block should return it.
  typedef struct {
    logic [fssa_pkg::HANDLE_W-1:0] handle;
    fssa_pkg::status_t             status;
    logic [fssa_pkg::COUNT_W-1:0]  bumped;
    logic [fssa_pkg::COUNT_W-1:0]  free_count;
    logic [fssa_pkg::BYTES_W-1:0]  usage;
    logic [fssa_pkg::BYTES_W-1:0]  peak;
  } slab_result_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic                          in_op     = 1'b0;
  logic [fssa_pkg::HANDLE_W-1:0] in_handle = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [fssa_pkg::HANDLE_W-1:0] out_result_handle;
  logic [fssa_pkg::STATUS_W-1:0] out_status;
  logic [fssa_pkg::COUNT_W-1:0]  out_bumped_count;
  logic [fssa_pkg::COUNT_W-1:0]  out_free_count;
  logic [fssa_pkg::BYTES_W-1:0]  out_usage_bytes;
  logic [fssa_pkg::BYTES_W-1:0]  out_peak_bytes;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [fssa_pkg::APB_AW-1:0]   paddr     = '0;
  logic [fssa_pkg::APB_DW-1:0]   pwdata    = '0;
  logic [fssa_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  // Register mirror, updated when a configuration write lands.
  int unsigned reg_item_size = 16;
  int unsigned reg_ipb_raw   = 32;
  int unsigned reg_limit     = 0;
  bit          reg_stats     = 1'b0;

  // Shadow allocator state, advanced once per accepted request.
  int unsigned                   shadow_slab  = 0;
  int unsigned                   shadow_slot  = 0;
  int unsigned                   shadow_top   = 0;
  logic [fssa_pkg::HANDLE_W-1:0] shadow_stack [fssa_pkg::STACK_DEPTH];
  int unsigned                   shadow_usage = 0;
  int unsigned                   shadow_peak  = 0;

  // Handles currently held by the requester; random frees pick from here.
  logic [fssa_pkg::HANDLE_W-1:0] held[$];
  // Results owed by the block, oldest first.
  slab_result_t                  expected_results[$];

  // Traffic shaping knobs, set per phase by the tests.
  int stall_pct  = 20;
  int gap_max    = 3;
  int burst_left = 0;
  int hold_req   = 0;
  int hold_left  = 0;
  int run_left   = 0;
  bit run_stall  = 1'b0;

  // Bookkeeping for the closing summary.
  int mismatches      = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int status_seen [5];

  fixed_size_slab_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_handle         (in_handle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_bumped_count  (out_bumped_count),
    .out_free_count    (out_free_count),
    .out_usage_bytes   (out_usage_bytes),
    .out_peak_bytes    (out_peak_bytes),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 4 ns period: 2 ns high, 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Slab size as the block uses it: zero acts as one, oversize clamps to the maximum.
  function automatic int unsigned clamped_slab_size();
    if (reg_ipb_raw == 0) return 1;
    if (reg_ipb_raw > fssa_pkg::MAX_ITEMS_PER_SLAB) return fssa_pkg::MAX_ITEMS_PER_SLAB;
    return reg_ipb_raw;
  endfunction

  // Charge one item to usage; return 1 only when peak first rises above the limit.
  function automatic bit charge_usage();
    longint unsigned sum;
    int unsigned     prev;
    if (!reg_stats) return 1'b0;
    sum = shadow_usage;
    sum += reg_item_size;
    // saturate at the top of the byte counter
    shadow_usage = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    if (shadow_usage > shadow_peak) begin
      prev        = shadow_peak;
      shadow_peak = shadow_usage;
      if (reg_limit != 0 && shadow_peak > reg_limit && prev <= reg_limit) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the result of one request and advance the shadow state.
  function automatic slab_result_t predict_slab_op(input fssa_pkg::op_t op,
                                                   input logic [fssa_pkg::HANDLE_W-1:0] h);
    slab_result_t r;
    int unsigned  ipb;
    int unsigned  cap;
    bit           need_new;
    ipb      = clamped_slab_size();
    r.handle = '0;
    r.status = fssa_pkg::ST_OK;
    if (op == fssa_pkg::OP_ALLOC) begin
      if (shadow_top > 0) begin
        // reuse the most recently freed handle
        if (charge_usage()) begin
          r.status = fssa_pkg::ST_LIMIT;
        end else begin
          shadow_top--;
          r.handle = shadow_stack[shadow_top];
          held.insert(held.size(), r.handle);
        end
      end else begin
        // bump; a slot count at or past the current slab size means the slab is full
        need_new = (shadow_slot >= ipb);
        if (need_new && shadow_slab + 1 >= fssa_pkg::MAX_SLABS) begin
          r.status = fssa_pkg::ST_NO_SLAB;
        end else if (charge_usage()) begin
          r.status = fssa_pkg::ST_LIMIT;
        end else begin
          if (need_new) begin
            shadow_slab++;
            shadow_slot = 0;
          end
          r.handle = fssa_pkg::HANDLE_W'(shadow_slab * ipb + shadow_slot);
          shadow_slot++;
          held.insert(held.size(), r.handle);
        end
      end
    end else begin
      cap = (shadow_slab + 1) * ipb;
      if (h >= cap) begin
        r.status = fssa_pkg::ST_BAD_HDL;
      end else if (shadow_top >= ((cap > fssa_pkg::STACK_DEPTH) ?
                                  fssa_pkg::STACK_DEPTH : cap)) begin
        r.status = fssa_pkg::ST_FULL;
      end else begin
        shadow_stack[shadow_top] = h;
        shadow_top++;
        if (reg_stats) begin
          shadow_usage = (shadow_usage < reg_item_size) ? 0 : shadow_usage - reg_item_size;
        end
        // drop one copy from the held list; double frees simply find none
        for (int k = 0; k < held.size(); k++) begin
          if (held[k] == h) begin
            held.delete(k);
            break;
          end
        end
      end
    end
    r.bumped     = fssa_pkg::COUNT_W'(shadow_slab * ipb + shadow_slot);
    r.free_count = fssa_pkg::COUNT_W'(shadow_top);
    r.usage      = shadow_usage;
    r.peak       = shadow_peak;
    return r;
  endfunction

  // Offer one request transaction, hold it through stalls, predict on acceptance.
  // Between bursts drop valid for a random gap.
  task automatic send(input fssa_pkg::op_t op, input logic [fssa_pkg::HANDLE_W-1:0] h);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_op     <= op;
    in_handle <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.insert(expected_results.size(), predict_slab_op(op, h));
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(12, 1);
      if (gap_max > 0) begin
        gap = $urandom_range(gap_max, 1);
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Idle the input and wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input fssa_pkg::reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fssa_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      fssa_pkg::REG_ITEM_SIZE:  reg_item_size = value & 32'hFFFF;
      fssa_pkg::REG_ITEMS_SLAB: reg_ipb_raw   = value & 32'hFF;
      fssa_pkg::REG_MEM_LIMIT:  reg_limit     = value;
      fssa_pkg::REG_STATS_EN:   reg_stats     = value[0];
      default: ;
    endcase
    @(negedge clk) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  // Reconfigure only once the block has gone idle.
  task automatic set_config(input logic [15:0] size, input logic [7:0] ipb,
                            input logic [31:0] limit, input bit stats);
    drain_results();
    write_reg(fssa_pkg::REG_ITEM_SIZE, 32'(size));
    write_reg(fssa_pkg::REG_ITEMS_SLAB, 32'(ipb));
    write_reg(fssa_pkg::REG_MEM_LIMIT, limit);
    write_reg(fssa_pkg::REG_STATS_EN, 32'(stats));
  endtask

  // Random traffic: mostly allocs and frees of held handles, some junk frees.
  // Halfway through, ask the receiver for a long hold-off so the input backs up.
  task automatic run_mixed_traffic(input int n_items, input int alloc_pct,
                                   input int stall_p, input int gap_m);
    int                            pick;
    int                            idx;
    int unsigned                   edge_h;
    logic [fssa_pkg::HANDLE_W-1:0] h;
    stall_pct = stall_p;
    gap_max   = gap_m;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) hold_req = 64 + $urandom_range(48);
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        send(fssa_pkg::OP_ALLOC, fssa_pkg::HANDLE_W'($urandom));
      end else if (pick < 93 && held.size() > 0) begin
        idx = $urandom_range(held.size() - 1);
        send(fssa_pkg::OP_FREE, held[idx]);
      end else begin
        edge_h = (shadow_slab + 1) * clamped_slab_size();
        case ($urandom_range(2))
          0:       h = fssa_pkg::HANDLE_W'($urandom);
          1:       h = fssa_pkg::HANDLE_W'(edge_h);
          default: h = fssa_pkg::HANDLE_W'(edge_h - 1);
        endcase
        send(fssa_pkg::OP_FREE, h);
      end
    end
  endtask

  // Bump allocs, a reuse from the stack, rejected frees at and past the slab edge.
  task automatic test_basic_alloc_free();
    send(fssa_pkg::OP_ALLOC, '1);
    send(fssa_pkg::OP_ALLOC, '0);
    send(fssa_pkg::OP_ALLOC, fssa_pkg::HANDLE_W'($urandom));
    send(fssa_pkg::OP_FREE, fssa_pkg::HANDLE_W'(1));
    send(fssa_pkg::OP_ALLOC, '0);
    send(fssa_pkg::OP_FREE, '1);
    send(fssa_pkg::OP_FREE, fssa_pkg::HANDLE_W'(32));
    send(fssa_pkg::OP_FREE, fssa_pkg::HANDLE_W'(31));
    send(fssa_pkg::OP_ALLOC, '0);
  endtask

  // First crossing of the limit on the bump path, then on the reuse path,
  // with usage pinned at zero by one extra free along the way.
  task automatic test_limit_crossing();
    set_config(16'hFFFF, 32, 100000, 1'b1);
    repeat (3) send(fssa_pkg::OP_ALLOC, '0);
    set_config(16'hFFFF, 32, 200000, 1'b1);
    repeat (4) send(fssa_pkg::OP_FREE, held[held.size() - 1]);
    repeat (5) send(fssa_pkg::OP_ALLOC, '0);
  endtask

  // Slab size zero acts as one: open every slab, then run out.
  task automatic test_slab_exhaustion();
    set_config(1, 0, 0, 1'b0);
    while (!(shadow_slab == fssa_pkg::MAX_SLABS - 1 && shadow_slot >= clamped_slab_size() &&
             shadow_top == 0)) begin
      send(fssa_pkg::OP_ALLOC, fssa_pkg::HANDLE_W'($urandom));
    end
    repeat (2) send(fssa_pkg::OP_ALLOC, '1);
  endtask

  // Fill the free stack to the opened capacity and push past it.
  task automatic test_stack_full();
    int unsigned cap;
    set_config(1, 1, 0, 1'b0);
    cap = (shadow_slab + 1) * clamped_slab_size();
    if (cap > fssa_pkg::STACK_DEPTH) cap = fssa_pkg::STACK_DEPTH;
    while (shadow_top < cap) begin
      send(fssa_pkg::OP_FREE, fssa_pkg::HANDLE_W'($urandom_range(cap - 1)));
    end
    repeat (2) send(fssa_pkg::OP_FREE, fssa_pkg::HANDLE_W'($urandom_range(cap - 1)));
    send(fssa_pkg::OP_FREE, fssa_pkg::HANDLE_W'(cap));
    send(fssa_pkg::OP_ALLOC, '0);
  endtask

  // Random traffic while slabs are still being opened.
  task automatic test_random_slab_growth();
    set_config(16, 32, 0, 1'b1);
    run_mixed_traffic(230, 58, 25, 4);
    set_config(16'hFFFF, 100, shadow_peak + 3 * 65535, 1'b1);
    run_mixed_traffic(230, 55, 50, 6);
  endtask

  // Random traffic after exhaustion, across slab sizes, byte sizes and limits.
  task automatic test_random_reuse();
    set_config(1, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    run_mixed_traffic(230, 55, 0, 0);
    set_config(16'($urandom_range(65535, 1)), 5, 0, 1'b0);
    run_mixed_traffic(230, 45, 35, 5);
    set_config(16'hFFFF, 128, shadow_peak + 2 * 65535, 1'b1);
    run_mixed_traffic(230, 60, 60, 3);
    set_config(16'($urandom_range(300, 1)), 8'($urandom_range(127, 2)), $urandom, 1'b1);
    run_mixed_traffic(230, 50, 30, 7);
  endtask

  // Receiver: random runs of stall and no-stall; a hold-off request overrides them.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_left  = $urandom_range(6, 1);
        run_stall = ($urandom_range(99) < stall_pct);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    slab_result_t oldest;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("result_handle", 32'(oldest.handle), 32'(out_result_handle));
        check_field("status", 32'(oldest.status), 32'(out_status));
        check_field("bumped_count", 32'(oldest.bumped), 32'(out_bumped_count));
        check_field("free_count", 32'(oldest.free_count), 32'(out_free_count));
        check_field("usage_bytes", oldest.usage, out_usage_bytes);
        check_field("peak_bytes", oldest.peak, out_peak_bytes);
        status_seen[int'(oldest.status)]++;
        results_checked++;
      end
    end
  end

  // Main sequence: reset once, run the tests in order, then report.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_basic_alloc_free();
    test_limit_crossing();
    test_random_slab_growth();
    test_slab_exhaustion();
    test_stack_full();
    test_random_reuse();
    drain_results();
    $display("covered %0d requests, %0d results checked: %0d ok, %0d limit, %0d no slab,",
             items_sent, results_checked, status_seen[0], status_seen[1], status_seen[2]);
    $display("  %0d bad handle, %0d stack full; %0d slabs opened, peak %0d bytes",
             status_seen[3], status_seen[4], shadow_slab + 1, shadow_peak);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
